### rtl/slri_pkg.sv
// ----------------------------------------------------------------------------
// slri_pkg
// Shared types and constants for the sorted list cell chain.
// ----------------------------------------------------------------------------
package slri_pkg;

  localparam int Capacity    = 16;
  localparam int ValueW      = 32;
  localparam int CntW        = $clog2(Capacity + 1);
  localparam int EntryCountW = 5;

  typedef enum logic [0:0] {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatusDone     = 2'd0,
    StatusFull     = 2'd1,
    StatusNotFound = 2'd2
  } status_e;

  // what each cell shows its neighbors and the controller
  typedef struct packed {
    logic                     occ;
    logic                     le;   // stored value <= command value
    logic                     lt;   // stored value <  command value
    logic                     eq;
    logic signed [ValueW-1:0] value;
  } cell_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                     cmp_en;
    logic                     ins_en;   // insert, list not full
    logic                     rem_en;   // remove, value present
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

### rtl/slri_cell.sv
// ----------------------------------------------------------------------------
// slri_cell
// One slot of the sorted list: compares against the broadcast value, then
// keeps, takes the new value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module slri_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slri_pkg::cell_ctrl_t ctrl_i,
  input  slri_pkg::cell_t   left_i,
  input  slri_pkg::cell_t   right_i,
  output slri_pkg::cell_t   cell_o
);
  import slri_pkg::*;

  logic                     occ_q, occ_d;
  logic                     le_q, lt_q, eq_q;
  logic signed [ValueW-1:0] value_q, value_d;

  always_comb begin
    occ_d   = occ_q;
    value_d = value_q;
    if (ctrl_i.ins_en && !le_q) begin
      if (left_i.le) begin
        // insert point: first slot past all entries <= value
        occ_d   = 1'b1;
        value_d = ctrl_i.value;
      end else begin
        occ_d   = left_i.occ;
        value_d = left_i.value;
      end
    end else if (ctrl_i.rem_en && !lt_q) begin
      occ_d   = right_i.occ;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      le_q  <= 1'b0;
      lt_q  <= 1'b0;
      eq_q  <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (ctrl_i.cmp_en) begin
        le_q <= occ_q && (value_q <= ctrl_i.value);
        lt_q <= occ_q && (value_q <  ctrl_i.value);
        eq_q <= occ_q && (value_q == ctrl_i.value);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o = '{occ: occ_q, le: le_q, lt: lt_q, eq: eq_q, value: value_q};

endmodule

### rtl/sorted_list_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove
// Bounded ascending list of signed values held in a chain of cells; insert
// after equal entries, remove the first equal entry.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o   | command_i, value_i
//  out     | output    | out_valid_o / out_stall_i | status_o, entry_count_o,
//          |           |                           | smallest_value_o
//
// Each item goes through a compare state, where every cell compares its entry
// with the value, then a shift state, where the chain shifts by one slot. The
// next item is taken in the shift state, while the last item shifts.
// Reset empties the list at once; stored values need no clearing.
// A stalled result holds the shift cycle until the output register frees.
module sorted_list_insert_remove (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [0:0]                    command_i,
  input  logic signed [slri_pkg::ValueW-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [slri_pkg::EntryCountW-1:0] entry_count_o,
  output logic signed [slri_pkg::ValueW-1:0] smallest_value_o
);
  import slri_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StCmp  = 3'b010,
    StUpd  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                     cmd_q;
  logic signed [ValueW-1:0] value_q;
  logic [CntW-1:0]          count_q, count_d;

  logic                     out_valid_q;
  logic [1:0]               status_q, status_d;
  logic [CntW-1:0]          res_count_q;
  logic signed [ValueW-1:0] smallest_q, smallest_d;

  cell_t      cells [Capacity];
  cell_t      left_tie, right_tie;
  cell_ctrl_t ctrl;
  logic [Capacity-1:0] occ_vec, eq_vec;

  logic out_free, advance, accept, found, full;

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = (state_q == StUpd) && out_free;
  assign in_stall_o = !((state_q == StIdle) || advance);
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      occ_vec[i] = cells[i].occ;
      eq_vec[i]  = cells[i].eq;
    end
  end

  assign found = |eq_vec;
  assign full  = occ_vec[Capacity-1];

  assign left_tie  = '{occ: 1'b1, le: 1'b1, lt: 1'b1, eq: 1'b0, value: '0};
  assign right_tie = '{occ: 1'b0, le: 1'b0, lt: 1'b0, eq: 1'b0, value: '0};

  assign ctrl = '{
    cmp_en: (state_q == StCmp),
    ins_en: advance && (cmd_q == CmdInsert) && !full,
    rem_en: advance && (cmd_q == CmdRemove) && found,
    value:  value_q
  };

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    slri_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  ((g == 0) ? left_tie : cells[(g == 0) ? 0 : g - 1]),
      .right_i ((g == Capacity - 1) ? right_tie
                                     : cells[(g == Capacity - 1) ? g : g + 1]),
      .cell_o  (cells[g])
    );
  end

  // result as seen after the shift
  always_comb begin
    count_d    = count_q;
    status_d   = StatusDone;
    smallest_d = cells[0].occ ? cells[0].value : '0;
    if (cmd_q == CmdInsert) begin
      if (full) begin
        status_d = StatusFull;
      end else begin
        count_d = count_q + CntW'(1);
        if (!cells[0].le) smallest_d = value_q;
      end
    end else begin
      if (!found) begin
        status_d = StatusNotFound;
      end else begin
        count_d = count_q - CntW'(1);
        // first match in slot 0: slot 1 moves down
        if (!cells[0].lt) smallest_d = cells[1].occ ? cells[1].value : '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = StCmp;
      StCmp:   state_d = StUpd;
      StUpd:   if (advance) state_d = accept ? StCmp : StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (advance) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i[0];
      value_q <= value_i;
    end
    if (advance) begin
      status_q    <= status_d;
      res_count_q <= count_d;
      smallest_q  <= smallest_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign entry_count_o    = EntryCountW'(res_count_q);
  assign smallest_value_o = smallest_q;

`ifndef ASSERT_OFF
  // occupied slots always match the entry count
  a_count_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == 32'(count_q))
    else $error("occupied slots disagree with entry count");

  // full flag is the last slot being occupied
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full == (count_q == CntW'(Capacity)))
    else $error("full flag disagrees with entry count");

  // a result appears only after a shift cycle
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StUpd))
    else $error("result produced outside the shift cycle");

  // the compare cycle always follows an accepted item
  a_cmp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmp) |-> $past(accept))
    else $error("compare cycle without an accepted item");
`endif

endmodule
